// ===== hdl/ffhp_pkg.sv =====
// Shared types and constants of the FLAC frame header parser.
package ffhp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCK_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 2'd2;

    localparam int OUT_TDATA_W = 112;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_SYNC      = 3'd1,
        ST_RESERVED      = 3'd2,
        ST_SIZE_MISMATCH = 3'd3,
        ST_BAD_NUMBER    = 3'd4,
        ST_SIZE_CODE0    = 3'd5,
        ST_RATE_CODE15   = 3'd6,
        ST_CRC_MISMATCH  = 3'd7
    } status_t;

    // Raw header result handed from the byte parser to the field decoder
    typedef struct packed {
        status_t     status;
        logic        ok;
        logic        variable_blocking;
        logic [3:0]  size_code;
        logic [3:0]  rate_code;
        logic [3:0]  channel_assign;
        logic [2:0]  depth_code;
        logic [35:0] number;
        logic [15:0] size_extra;
        logic [15:0] rate_extra;
        logic [4:0]  header_length;
    } hdr_result_t;

endpackage

// ===== hdl/ffhp_parser.sv =====
// Byte-at-a-time header state machine with running CRC-8 and result register.
module ffhp_parser
    import ffhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [15:0] min_block_size,
    input  logic [15:0] max_block_size,
    output logic        res_valid,
    input  logic        res_ready,
    output hdr_result_t res
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SYNC1    = 4'd1,
        PH_SYNC2    = 4'd2,
        PH_CODES    = 4'd3,
        PH_CHAN     = 4'd4,
        PH_NUM_LEAD = 4'd5,
        PH_NUM_CONT = 4'd6,
        PH_SIZE_X   = 4'd7,
        PH_RATE_X   = 4'd8,
        PH_CRC      = 4'd9
    } phase_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++)
        begin
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h07) : {x[6:0], 1'b0};
        end
        return x;
    endfunction

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [7:0]  crc_reg, crc_next;
    logic        strat_reg, strat_next;
    logic [3:0]  size_reg, size_next;
    logic [3:0]  rate_reg, rate_next;
    logic [3:0]  chan_reg, chan_next;
    logic [2:0]  depth_reg, depth_next;
    logic [35:0] accum_reg, accum_next;
    logic [2:0]  cont_reg, cont_next;
    logic [15:0] sx_reg, sx_next;
    logic [15:0] rx_reg, rx_next;
    logic [1:0]  left_reg, left_next;
    logic [4:0]  count_reg, count_next;

    logic        res_valid_reg, res_valid_next;
    hdr_result_t res_reg, res_next;

    logic        accept;
    logic        emit;
    logic        ok;
    status_t     status;
    logic [3:0]  lead;

    assign in_ready  = !res_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign lead      = lead_ones(data_byte);

    always_comb
    begin
        phase_t      ph;
        logic        after_num;
        logic        after_size;
        // a start marker drops any header in progress
        if (first_byte)
        begin
            ph         = PH_SYNC1;
            crc_next   = 8'd0;
            strat_next = 1'b0;
            size_next  = 4'd0;
            rate_next  = 4'd0;
            chan_next  = 4'd0;
            depth_next = 3'd0;
            accum_next = 36'd0;
            cont_next  = 3'd0;
            sx_next    = 16'd0;
            rx_next    = 16'd0;
            left_next  = 2'd0;
            count_next = 5'd0;
        end
        else
        begin
            ph         = phase_reg;
            crc_next   = crc_reg;
            strat_next = strat_reg;
            size_next  = size_reg;
            rate_next  = rate_reg;
            chan_next  = chan_reg;
            depth_next = depth_reg;
            accum_next = accum_reg;
            cont_next  = cont_reg;
            sx_next    = sx_reg;
            rx_next    = rx_reg;
            left_next  = left_reg;
            count_next = count_reg;
        end
        phase_next = ph;
        emit       = 1'b0;
        ok         = 1'b0;
        status     = ST_OK;
        after_num  = 1'b0;
        after_size = 1'b0;

        if (ph != PH_IDLE)
        begin
            count_next = count_next + 5'd1;
            if (ph == PH_CRC)
            begin
                emit = 1'b1;
                if (crc_next == data_byte)
                begin
                    ok = 1'b1;
                end
                else
                begin
                    status = ST_CRC_MISMATCH;
                end
            end
            else
            begin
                crc_next = crc8_step(crc_next, data_byte);
                case (ph)
                    PH_SYNC1:
                    begin
                        if (data_byte != 8'hFF)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_SYNC;
                        end
                        else
                        begin
                            phase_next = PH_SYNC2;
                        end
                    end
                    PH_SYNC2:
                    begin
                        if (data_byte[7:2] != 6'b111110)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_SYNC;
                        end
                        else
                        begin
                            strat_next = data_byte[0];
                            size_next  = 4'd0;
                            rate_next  = 4'd0;
                            chan_next  = 4'd0;
                            depth_next = 3'd0;
                            if (data_byte[1])
                            begin
                                emit   = 1'b1;
                                status = ST_RESERVED;
                            end
                            else
                            begin
                                phase_next = PH_CODES;
                            end
                        end
                    end
                    PH_CODES:
                    begin
                        size_next  = data_byte[7:4];
                        rate_next  = data_byte[3:0];
                        chan_next  = 4'd0;
                        depth_next = 3'd0;
                        phase_next = PH_CHAN;
                    end
                    PH_CHAN:
                    begin
                        chan_next  = data_byte[7:4];
                        depth_next = data_byte[3:1];
                        if (data_byte[0])
                        begin
                            emit   = 1'b1;
                            status = ST_RESERVED;
                        end
                        else if (!strat_next && (min_block_size != max_block_size))
                        begin
                            emit   = 1'b1;
                            status = ST_SIZE_MISMATCH;
                        end
                        else
                        begin
                            phase_next = PH_NUM_LEAD;
                        end
                    end
                    PH_NUM_LEAD:
                    begin
                        if (lead == 4'd0)
                        begin
                            accum_next = {28'd0, data_byte};
                            after_num  = 1'b1;
                        end
                        else if (lead == 4'd1 || lead == 4'd8 || (!strat_next && lead == 4'd7))
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_NUMBER;
                        end
                        else
                        begin
                            accum_next = {28'd0, data_byte & (8'hFF >> (lead + 4'd1))};
                            cont_next  = lead[2:0] - 3'd1;
                            phase_next = PH_NUM_CONT;
                        end
                    end
                    PH_NUM_CONT:
                    begin
                        if (data_byte[7:6] != 2'b10)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_NUMBER;
                        end
                        else
                        begin
                            accum_next = {accum_next[29:0], data_byte[5:0]};
                            cont_next  = cont_next - 3'd1;
                            if (cont_next == 3'd0)
                            begin
                                after_num = 1'b1;
                            end
                        end
                    end
                    PH_SIZE_X:
                    begin
                        sx_next   = {sx_next[7:0], data_byte};
                        left_next = left_next - 2'd1;
                        if (left_next == 2'd0)
                        begin
                            after_size = 1'b1;
                        end
                    end
                    PH_RATE_X:
                    begin
                        rx_next   = {rx_next[7:0], data_byte};
                        left_next = left_next - 2'd1;
                        if (left_next == 2'd0)
                        begin
                            phase_next = PH_CRC;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (after_num)
                begin
                    case (size_next)
                        4'd0:
                        begin
                            emit   = 1'b1;
                            status = ST_SIZE_CODE0;
                        end
                        4'd6:
                        begin
                            left_next  = 2'd1;
                            sx_next    = 16'd0;
                            phase_next = PH_SIZE_X;
                        end
                        4'd7:
                        begin
                            left_next  = 2'd2;
                            sx_next    = 16'd0;
                            phase_next = PH_SIZE_X;
                        end
                        default:
                        begin
                            after_size = 1'b1;
                        end
                    endcase
                end

                if (after_size)
                begin
                    case (rate_next)
                        4'hF:
                        begin
                            emit   = 1'b1;
                            status = ST_RATE_CODE15;
                        end
                        4'hC:
                        begin
                            left_next  = 2'd1;
                            rx_next    = 16'd0;
                            phase_next = PH_RATE_X;
                        end
                        4'hD, 4'hE:
                        begin
                            left_next  = 2'd2;
                            rx_next    = 16'd0;
                            phase_next = PH_RATE_X;
                        end
                        default:
                        begin
                            phase_next = PH_CRC;
                        end
                    endcase
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        res_next.status            = status;
        res_next.ok                = ok;
        res_next.variable_blocking = strat_next;
        res_next.size_code         = size_next;
        res_next.rate_code         = rate_next;
        res_next.channel_assign    = chan_next;
        res_next.depth_code        = depth_next;
        res_next.number            = accum_next;
        res_next.size_extra        = sx_next;
        res_next.rate_extra        = rx_next;
        res_next.header_length     = count_next;
    end

    always_comb
    begin
        if (accept)
        begin
            res_valid_next = emit;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            crc_reg       <= 8'd0;
            strat_reg     <= 1'b0;
            size_reg      <= 4'd0;
            rate_reg      <= 4'd0;
            chan_reg      <= 4'd0;
            depth_reg     <= 3'd0;
            accum_reg     <= 36'd0;
            cont_reg      <= 3'd0;
            sx_reg        <= 16'd0;
            rx_reg        <= 16'd0;
            left_reg      <= 2'd0;
            count_reg     <= 5'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                crc_reg   <= crc_next;
                strat_reg <= strat_next;
                size_reg  <= size_next;
                rate_reg  <= rate_next;
                chan_reg  <= chan_next;
                depth_reg <= depth_next;
                accum_reg <= accum_next;
                cont_reg  <= cont_next;
                sx_reg    <= sx_next;
                rx_reg    <= rx_next;
                left_reg  <= left_next;
                count_reg <= count_next;
            end
        end
    end

    // hold the payload while the decoder stalls
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/ffhp_decode.sv =====
// Field decode stage: sample number scaling, block size and sample rate tables.
module ffhp_decode
    import ffhp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  hdr_result_t            res,
    input  logic [15:0]            min_block_size,
    input  logic [19:0]            stream_hz,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic [2:0]             out_status
);

    function automatic logic [16:0] block_size(input logic [3:0] sc, input logic [15:0] ex);
        logic [16:0] bs;
        case (sc) inside
            4'd0:          bs = 17'd0;
            4'd1:          bs = 17'd192;
            [4'd2:4'd5]:   bs = 17'd576 << (sc - 4'd2);
            4'd6:          bs = {9'd0, ex[7:0]} + 17'd1;
            4'd7:          bs = {1'b0, ex} + 17'd1;
            default:       bs = 17'd256 << (sc - 4'd8);
        endcase
        return bs;
    endfunction

    function automatic logic [19:0] rate_hz(input logic [3:0] rc, input logic [15:0] ex,
                                            input logic [19:0] stream_rate);
        logic [19:0] sr;
        case (rc)
            4'h0:    sr = stream_rate;
            4'h1:    sr = 20'd88200;
            4'h2:    sr = 20'd176400;
            4'h3:    sr = 20'd192000;
            4'h4:    sr = 20'd8000;
            4'h5:    sr = 20'd16000;
            4'h6:    sr = 20'd22050;
            4'h7:    sr = 20'd24000;
            4'h8:    sr = 20'd32000;
            4'h9:    sr = 20'd44100;
            4'hA:    sr = 20'd48000;
            4'hB:    sr = 20'd96000;
            4'hC:    sr = {12'd0, ex[7:0]} * 20'd1000;
            4'hD:    sr = {4'd0, ex};
            4'hE:    sr = {4'd0, ex} * 20'd10;
            default: sr = 20'd0;
        endcase
        return sr;
    endfunction

    logic        valid_reg;
    logic        take;
    logic [51:0] product;
    logic [46:0] fs_next, fs_reg;
    logic [16:0] bs_next, bs_reg;
    logic [19:0] sr_next, sr_reg;
    hdr_result_t raw_reg;

    assign res_ready = !valid_reg || out_ready;
    assign take      = res_valid && res_ready;

    assign product = {16'd0, res.number} * {36'd0, min_block_size};

    always_comb
    begin
        if (!res.ok)
        begin
            fs_next = 47'd0;
            bs_next = 17'd0;
            sr_next = 20'd0;
        end
        else
        begin
            fs_next = res.variable_blocking ? {11'd0, res.number} : product[46:0];
            bs_next = block_size(res.size_code, res.size_extra);
            sr_next = rate_hz(res.rate_code, res.rate_extra, stream_hz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            raw_reg <= res;
            fs_reg  <= fs_next;
            bs_reg  <= bs_next;
            sr_reg  <= sr_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = raw_reg.status;
    assign out_data   = {7'd0, raw_reg.header_length, sr_reg, bs_reg, fs_reg,
                         raw_reg.depth_code, raw_reg.channel_assign, raw_reg.rate_code,
                         raw_reg.size_code, raw_reg.variable_blocking};

endmodule

// ===== hdl/flac_frame_header_parser_top.sv =====
// Top level of the FLAC frame header parser: config registers, parser and decoder.
// Throughput: one header byte per cycle; s_tready drops only while both result
// registers hold a report and m_tready is low.
// Result path: the report of the byte that completes or fails the header passes the
// parser result register, then the decode register, before it shows on m_tvalid.
// Reset: rst_n clears the config registers to zero and puts the parser in idle,
// where bytes are dropped until one arrives with the start flag.
module flac_frame_header_parser_top
    import ffhp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] first_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] variable_blocking, [4:1] size_code, [8:5] rate_code, [12:9] channel_assign,
    // [15:13] depth_code, [62:16] first_sample, [79:63] frame_block_size,
    // [99:80] frame_sample_rate, [104:100] header_length, [111:105] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]             m_tuser,   // [2:0] status
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [15:0] min_block_reg;
    logic [15:0] max_block_reg;
    logic [19:0] rate_reg;

    logic        res_valid;
    logic        res_ready;
    hdr_result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_block_reg <= 16'd0;
            max_block_reg <= 16'd0;
            rate_reg      <= 20'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_BLOCK_SIZE: min_block_reg <= cfg_data[15:0];
                REG_MAX_BLOCK_SIZE: max_block_reg <= cfg_data[15:0];
                REG_SAMPLE_RATE:    rate_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    ffhp_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .data_byte      (s_tdata),
        .first_byte     (s_tuser),
        .min_block_size (min_block_reg),
        .max_block_size (max_block_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    ffhp_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .min_block_size (min_block_reg),
        .stream_hz      (rate_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (m_tdata),
        .out_status     (m_tuser)
    );

endmodule

// ===== tb/sv/flac_frame_header_parser_top_tb.sv =====
// Self-checking testbench for the FLAC frame header parser top level.
`timescale 1ns / 100ps

module flac_frame_header_parser_top_tb
    import ffhp_pkg::*;
();

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 27;

    localparam int DMG_NONE     = 0;
    localparam int DMG_BAD_CRC  = 1;
    localparam int DMG_NOISE    = 2;
    localparam int DMG_TRUNCATE = 3;

    typedef enum logic [3:0] {
        WAIT_START, SYNC_HI, SYNC_LO, CODE_BYTE, CHAN_BYTE,
        NUM_LEAD, NUM_CONT, SIZE_EXT, RATE_EXT, CRC_BYTE
    } parse_step_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    typedef struct packed {
        status_t     status;
        logic        variable_blocking;
        logic [3:0]  size_code;
        logic [3:0]  rate_code;
        logic [3:0]  channel_assign;
        logic [2:0]  depth_code;
        logic [46:0] first_sample;
        logic [16:0] block_size;
        logic [19:0] frame_hz;
        logic [4:0]  header_length;
    } header_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MIN_BLOCK_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // stimulus and checking state
    stream_byte_t   pending_bytes[$];
    stream_byte_t   next_byte;
    header_report_t expected_headers[$];
    header_report_t want;
    int             queued_count = 0;
    int             error_count = 0;
    int             cycle_count = 0;
    int             hold_count = 0;
    logic           hold_armed = 1'b0;
    logic           steady = 1'b0;
    wire            rx_hold = hold_armed && (hold_count < HOLD_CYCLES);

    // parser mirror
    parse_step_t p_step;
    logic [7:0]  p_crc;
    logic        p_var;
    logic [3:0]  p_size, p_rate, p_chan;
    logic [2:0]  p_depth;
    logic [35:0] p_number;
    logic [2:0]  p_cont;
    logic [15:0] p_size_ext, p_rate_ext;
    logic [1:0]  p_ext_left;
    logic [4:0]  p_count;
    logic [15:0] cfg_min = '0, cfg_max = '0;
    logic [19:0] cfg_rate = '0;

    flac_frame_header_parser_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
            r = r[7] ? ((r << 1) ^ 8'h07) : (r << 1);
        return r;
    endfunction

    function automatic void clear_parser();
        p_step     = WAIT_START;
        p_crc      = '0;
        p_var      = 1'b0;
        p_size     = '0;
        p_rate     = '0;
        p_chan     = '0;
        p_depth    = '0;
        p_number   = '0;
        p_cont     = '0;
        p_size_ext = '0;
        p_rate_ext = '0;
        p_ext_left = '0;
        p_count    = '0;
    endfunction

    function automatic void finish_header(input status_t st);
        header_report_t r;
        logic [51:0]    prod;
        r = '0;
        r.status            = st;
        r.variable_blocking = p_var;
        r.size_code         = p_size;
        r.rate_code         = p_rate;
        r.channel_assign    = p_chan;
        r.depth_code        = p_depth;
        r.header_length     = p_count;
        if (st == ST_OK)
        begin
            prod = p_var ? {16'd0, p_number} : {16'd0, p_number} * {36'd0, cfg_min};
            r.first_sample = prod[46:0];
            case (p_size)
                4'd1:                   r.block_size = 17'd192;
                4'd2, 4'd3, 4'd4, 4'd5: r.block_size = 17'd576 << (p_size - 4'd2);
                4'd6:                   r.block_size = {9'd0, p_size_ext[7:0]} + 17'd1;
                4'd7:                   r.block_size = {1'b0, p_size_ext} + 17'd1;
                default:                r.block_size = 17'd256 << (p_size - 4'd8);
            endcase
            case (p_rate)
                4'h0:    r.frame_hz = cfg_rate;
                4'h1:    r.frame_hz = 20'd88200;
                4'h2:    r.frame_hz = 20'd176400;
                4'h3:    r.frame_hz = 20'd192000;
                4'h4:    r.frame_hz = 20'd8000;
                4'h5:    r.frame_hz = 20'd16000;
                4'h6:    r.frame_hz = 20'd22050;
                4'h7:    r.frame_hz = 20'd24000;
                4'h8:    r.frame_hz = 20'd32000;
                4'h9:    r.frame_hz = 20'd44100;
                4'hA:    r.frame_hz = 20'd48000;
                4'hB:    r.frame_hz = 20'd96000;
                4'hC:    r.frame_hz = {12'd0, p_rate_ext[7:0]} * 20'd1000;
                4'hD:    r.frame_hz = {4'd0, p_rate_ext};
                4'hE:    r.frame_hz = {4'd0, p_rate_ext} * 20'd10;
                default: r.frame_hz = '0;
            endcase
        end
        expected_headers.push_back(r);
        p_step = WAIT_START;
    endfunction

    function automatic status_t size_done();
        if (p_rate == 4'hF)
            return ST_RATE_CODE15;
        if (p_rate == 4'hC)
        begin
            p_ext_left = 2'd1;
            p_rate_ext = '0;
            p_step     = RATE_EXT;
        end
        else if (p_rate == 4'hD || p_rate == 4'hE)
        begin
            p_ext_left = 2'd2;
            p_rate_ext = '0;
            p_step     = RATE_EXT;
        end
        else
            p_step = CRC_BYTE;
        return ST_OK;
    endfunction

    function automatic status_t number_done();
        if (p_size == 4'd0)
            return ST_SIZE_CODE0;
        if (p_size == 4'd6 || p_size == 4'd7)
        begin
            p_ext_left = (p_size == 4'd6) ? 2'd1 : 2'd2;
            p_size_ext = '0;
            p_step     = SIZE_EXT;
            return ST_OK;
        end
        return size_done();
    endfunction

    // Advance the parser mirror by one accepted byte; queue a report when a header ends.
    function automatic void predict_byte(input logic [7:0] b, input logic start);
        status_t st;
        int      lead;
        st = ST_OK;
        if (start)
        begin
            clear_parser();
            p_step = SYNC_HI;
        end
        if (p_step == WAIT_START)
            return;
        p_count = p_count + 5'd1;
        if (p_step == CRC_BYTE)
        begin
            finish_header((p_crc == b) ? ST_OK : ST_CRC_MISMATCH);
            return;
        end
        p_crc = crc8_next(p_crc, b);
        case (p_step)
            SYNC_HI:
            begin
                if (b != 8'hFF)
                    st = ST_BAD_SYNC;
                else
                    p_step = SYNC_LO;
            end
            SYNC_LO:
            begin
                if (b[7:2] != 6'b111110)
                    st = ST_BAD_SYNC;
                else
                begin
                    p_var = b[0];
                    if (b[1])
                        st = ST_RESERVED;
                    else
                        p_step = CODE_BYTE;
                end
            end
            CODE_BYTE:
            begin
                p_size = b[7:4];
                p_rate = b[3:0];
                p_step = CHAN_BYTE;
            end
            CHAN_BYTE:
            begin
                p_chan  = b[7:4];
                p_depth = b[3:1];
                if (b[0])
                    st = ST_RESERVED;
                else if (!p_var && cfg_min != cfg_max)
                    st = ST_SIZE_MISMATCH;
                else
                    p_step = NUM_LEAD;
            end
            NUM_LEAD:
            begin
                lead = 0;
                while (lead < 8 && b[7 - lead])
                    lead++;
                if (lead == 0)
                begin
                    p_number = {28'd0, b};
                    st = number_done();
                end
                else if (lead == 1 || lead == 8 || (!p_var && lead > 6))
                    st = ST_BAD_NUMBER;
                else
                begin
                    p_number = {28'd0, b & (8'hFF >> (lead + 1))};
                    p_cont   = 3'(lead - 1);
                    p_step   = NUM_CONT;
                end
            end
            NUM_CONT:
            begin
                if (b[7:6] != 2'b10)
                    st = ST_BAD_NUMBER;
                else
                begin
                    p_number = {p_number[29:0], b[5:0]};
                    p_cont   = p_cont - 3'd1;
                    if (p_cont == 3'd0)
                        st = number_done();
                end
            end
            SIZE_EXT:
            begin
                p_size_ext = {p_size_ext[7:0], b};
                p_ext_left = p_ext_left - 2'd1;
                if (p_ext_left == 2'd0)
                    st = size_done();
            end
            RATE_EXT:
            begin
                p_rate_ext = {p_rate_ext[7:0], b};
                p_ext_left = p_ext_left - 2'd1;
                if (p_ext_left == 2'd0)
                    p_step = CRC_BYTE;
            end
            default: p_step = WAIT_START;
        endcase
        if (st != ST_OK)
            finish_header(st);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned exp_val);
        error_count++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, exp_val);
    endtask

    // Byte source: present the next pending byte, hold it until the transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tuser  <= next_byte.start;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Report sink: compare each transaction with the oldest expected header.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_headers.size() == 0)
                    report_mismatch("unexpected report (status)", m_tuser, 0);
                else
                begin
                    want = expected_headers.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[0] != want.variable_blocking)
                        report_mismatch("variable_blocking", m_tdata[0], want.variable_blocking);
                    if (m_tdata[4:1] != want.size_code)
                        report_mismatch("size_code", m_tdata[4:1], want.size_code);
                    if (m_tdata[8:5] != want.rate_code)
                        report_mismatch("rate_code", m_tdata[8:5], want.rate_code);
                    if (m_tdata[12:9] != want.channel_assign)
                        report_mismatch("channel_assign", m_tdata[12:9], want.channel_assign);
                    if (m_tdata[15:13] != want.depth_code)
                        report_mismatch("depth_code", m_tdata[15:13], want.depth_code);
                    if (m_tdata[62:16] != want.first_sample)
                        report_mismatch("first_sample", m_tdata[62:16], want.first_sample);
                    if (m_tdata[79:63] != want.block_size)
                        report_mismatch("frame_block_size", m_tdata[79:63], want.block_size);
                    if (m_tdata[99:80] != want.frame_hz)
                        report_mismatch("frame_sample_rate", m_tdata[99:80], want.frame_hz);
                    if (m_tdata[104:100] != want.header_length)
                        report_mismatch("header_length", m_tdata[104:100], want.header_length);
                end
            end
            m_tready <= !rx_hold && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long receiver hold-off, counted once armed.
    always @(posedge clk)
    begin
        if (hold_armed && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("** flac_frame_header_parser_top: FAILED **");
            $finish;
        end
    end

    task automatic push_raw(input logic [7:0] data, input logic start);
        stream_byte_t sb;
        sb.data  = data;
        sb.start = start;
        pending_bytes.push_back(sb);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        push_raw(data, start);
        queued_count++;
    endtask

    task automatic set_stream_info(input logic [15:0] min_bs, input logic [15:0] max_bs,
                                   input logic [19:0] rate);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MIN_BLOCK_SIZE;
        cfg_data  <= {4'd0, min_bs};
        @(posedge clk);
        cfg_index <= REG_MAX_BLOCK_SIZE;
        cfg_data  <= {4'd0, max_bs};
        @(posedge clk);
        cfg_index <= REG_SAMPLE_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_min  = min_bs;
        cfg_max  = max_bs;
        cfg_rate = rate;
    endtask

    // Drop the parser back to idle, then wait for the stream and the reports to drain.
    task automatic settle();
        push_raw(8'h00, 1'b1);
        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_headers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_frame(input logic var_mode, input logic [3:0] sc, input logic [3:0] rc,
                               input logic [3:0] ch, input logic [2:0] dc, input int num_len,
                               input logic [35:0] number, input logic [15:0] sz_ext,
                               input logic [15:0] rt_ext, input int damage);
        logic [7:0]  hdr[$];
        logic [7:0]  lead_b;
        logic [7:0]  crc;
        logic [35:0] shifted;
        int          cut;
        hdr = {};
        hdr.push_back(8'hFF);
        hdr.push_back({7'b1111100, var_mode});
        hdr.push_back({sc, rc});
        hdr.push_back({ch, dc, 1'b0});
        if (num_len == 1)
            hdr.push_back({1'b0, number[6:0]});
        else
        begin
            shifted = number >> (6 * (num_len - 1));
            lead_b  = 8'hFF << (8 - num_len);
            lead_b  = lead_b | (shifted[7:0] & (8'hFF >> (num_len + 1)));
            hdr.push_back(lead_b);
            for (int k = num_len - 2; k >= 0; k--)
            begin
                shifted = number >> (6 * k);
                hdr.push_back({2'b10, shifted[5:0]});
            end
        end
        if (sc == 4'd7)
            hdr.push_back(sz_ext[15:8]);
        if (sc == 4'd6 || sc == 4'd7)
            hdr.push_back(sz_ext[7:0]);
        if (rc == 4'hD || rc == 4'hE)
            hdr.push_back(rt_ext[15:8]);
        if (rc == 4'hC || rc == 4'hD || rc == 4'hE)
            hdr.push_back(rt_ext[7:0]);
        if (damage == DMG_NOISE)
            hdr[$urandom_range(hdr.size() - 1)] = 8'($urandom_range(255));
        cut = (damage == DMG_TRUNCATE) ? $urandom_range(hdr.size() - 1, 1) : hdr.size();
        crc = '0;
        for (int k = 0; k < hdr.size(); k++)
            crc = crc8_next(crc, hdr[k]);
        for (int k = 0; k < cut; k++)
            push_byte(hdr[k], k == 0);
        if (damage == DMG_BAD_CRC)
            push_byte(crc ^ 8'($urandom_range(255, 1)), 1'b0);
        else if (damage != DMG_TRUNCATE)
            push_byte(crc, 1'b0);
    endtask

    task automatic queue_random_frame();
        logic        var_mode;
        logic [63:0] r64;
        logic [35:0] number;
        int          num_len;
        int          pick;
        int          damage;
        var_mode = 1'($urandom_range(1));
        if (var_mode)
            num_len = $urandom_range(7, 1);
        else
            num_len = ($urandom_range(19) == 0) ? 7 : $urandom_range(6, 1);
        pick = $urandom_range(9);
        r64  = {$urandom, $urandom};
        number = (pick < 3) ? '1 : (pick == 3) ? '0 : r64[35:0];
        pick = $urandom_range(99);
        damage = (pick < 70) ? DMG_NONE : (pick < 82) ? DMG_BAD_CRC :
                 (pick < 92) ? DMG_NOISE : DMG_TRUNCATE;
        queue_frame(var_mode, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    4'($urandom_range(15)), 3'($urandom_range(7)), num_len, number,
                    16'($urandom_range(65535)), 16'($urandom_range(65535)), damage);
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = queued_count + n_bytes;
        while (queued_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                queue_random_frame();
            else if (pick < 88)
            begin
                // stray bytes with no start flag, between headers or after an unfinished one
                repeat ($urandom_range(3, 1))
                    push_raw(8'($urandom_range(255)), 1'b0);
            end
            else
            begin
                // start marker followed by junk, sometimes past the first sync byte
                push_byte(($urandom_range(1) == 1) ? 8'hFF : 8'($urandom_range(255)), 1'b1);
                repeat ($urandom_range(5))
                    push_byte(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases on reset registers (fixed mode passes since min equals max)
        push_byte(8'h5A, 1'b0);
        push_byte(8'hFE, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFA, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hF8, 1'b0);
        queue_frame(1'b0, 4'd1, 4'h9, 4'd0, 3'd0, 1, 36'd0, 16'd0, 16'd0, DMG_NONE);
        queue_frame(1'b1, 4'd0, 4'h9, 4'd2, 3'd4, 1, 36'd5, 16'd0, 16'd0, DMG_NONE);
        queue_frame(1'b1, 4'd8, 4'hF, 4'd1, 3'd1, 1, 36'd0, 16'd0, 16'd0, DMG_NONE);
        queue_frame(1'b1, 4'd7, 4'hE, 4'd15, 3'd7, 7, '1, 16'hFFFF, 16'hFFFF, DMG_NONE);
        settle();

        set_stream_info(16'd4096, 16'd4096, 20'd44100);
        run_random(220);
        settle();

        // extremes, no idling on either side
        set_stream_info(16'hFFFF, 16'hFFFF, 20'hFFFFF);
        steady = 1'b1;
        run_random(220);
        settle();
        steady = 1'b0;

        // min and max differ: fixed-mode headers fail the size check
        set_stream_info(16'd1, 16'd2, 20'd0);
        run_random(150);
        hold_armed = 1'b1;
        repeat (80)
            push_byte(8'($urandom_range(254)), 1'b1);
        run_random(80);
        settle();

        set_stream_info(16'hFFFF, 16'd0, 20'd1);
        run_random(100);
        settle();

        set_stream_info(16'($urandom_range(65535)), 16'($urandom_range(65535)), 20'd0);
        cfg_min = cfg_max;
        set_stream_info(cfg_max, cfg_max, 20'($urandom_range(1048575)));
        run_random(250);
        settle();

        if (error_count == 0)
            $display("** flac_frame_header_parser_top: PASSED **");
        else
            $display("** flac_frame_header_parser_top: FAILED **");
        $finish;
    end

endmodule
